// File: hdl/ddfb_pkg.sv
package ddfb_pkg;

  localparam int unsigned DIGIT_COUNT = 8;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned CODE_W  = 4;

  localparam logic [POS_W:0]    DIGIT_COUNT_W = (POS_W + 1)'(DIGIT_COUNT);
  localparam logic [POS_W-1:0]  LAST_POS      = POS_W'(DIGIT_COUNT - 1);
  localparam logic [CODE_W-1:0] BLANK_CODE    = 4'hF;
  localparam logic [CODE_W-1:0] MAX_DIGIT     = 4'd9;

  // Reciprocal of ten scaled by two to the 35th; exact for every 32-bit value.
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;
  localparam int unsigned        PROD_W      = 2 * VALUE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [VALUE_W-1:0] quot;
    logic [CODE_W-1:0]  digit;
  } div_res_t;

  typedef struct packed {
    logic [ADDR_W-1:0] register_address;
    logic [CODE_W-1:0] digit_code;
    logic              last_frame;
  } frame_t;

endpackage

// File: hdl/ddfb_intf.sv
interface ddfb_req_if;
  logic                          valid;
  logic                          ready;
  logic [ddfb_pkg::POS_W-1:0]    start_digit;
  logic [ddfb_pkg::VALUE_W-1:0]  number_value;

  modport source (output valid, output start_digit, output number_value, input ready);
  modport sink (input valid, input start_digit, input number_value, output ready);
endinterface

interface ddfb_frame_if;
  logic                          valid;
  logic                          ready;
  logic [ddfb_pkg::ADDR_W-1:0]   register_address;
  logic [ddfb_pkg::CODE_W-1:0]   digit_code;
  logic                          last_frame;

  modport source (output valid, output register_address, output digit_code,
                  output last_frame, input ready);
  modport sink (input valid, input register_address, input digit_code,
                input last_frame, output ready);
endinterface

// File: hdl/ddfb_div10.sv
module ddfb_div10 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [ddfb_pkg::VALUE_W-1:0]  x_i,
  output ddfb_pkg::div_res_t            res_o
);
  import ddfb_pkg::*;

  logic [VALUE_W-1:0] x_q;
  logic [PROD_W-1:0]  prod_q;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] diff;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_i;
      prod_q <= PROD_W'(x_i) * PROD_W'(RECIP_TEN);
    end
  end

  assign quot  = VALUE_W'(prod_q[PROD_W-1:RECIP_SHIFT]);
  assign diff  = x_q - (quot << 3) - (quot << 1);
  assign res_o = '{quot: quot, digit: diff[CODE_W-1:0]};

`ifndef SYNTH
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> res_o.digit <= MAX_DIGIT)
    else $error("div10 digit out of range");

  a_quot_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> (res_o.quot * 10 + VALUE_W'(res_o.digit)) == x_q)
    else $error("div10 quotient and digit do not rebuild the value");
`endif

endmodule

// File: hdl/ddfb_ctrl.sv
module ddfb_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ddfb_req_if.sink                      req_i,
  input  ddfb_pkg::div_res_t            res_i,
  input  logic                          out_free_i,
  output logic                          div_en_o,
  output logic [ddfb_pkg::VALUE_W-1:0]  div_x_o,
  output logic                          frame_load_o,
  output ddfb_pkg::frame_t              frame_o
);
  import ddfb_pkg::*;

  state_e             state_q, state_d;
  logic [VALUE_W-1:0] rest_q, rest_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               first_q, first_d;
  logic               take_req;
  logic               blank;

  assign take_req = req_i.valid && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take_req && ({1'b0, req_i.start_digit} < DIGIT_COUNT_W)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free_i) begin
          state_d = (pos_q == LAST_POS) ? ST_IDLE : ST_MUL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign blank = (rest_q == '0) && !first_q;

  always_comb begin
    req_i.ready  = 1'b0;
    div_en_o     = 1'b0;
    frame_load_o = 1'b0;
    rest_d       = rest_q;
    pos_d        = pos_q;
    first_d      = first_q;
    unique case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (take_req) begin
          rest_d  = req_i.number_value;
          pos_d   = req_i.start_digit;
          first_d = 1'b1;
        end
      end
      ST_MUL: begin
        div_en_o = 1'b1;
      end
      ST_EMIT: begin
        if (out_free_i) begin
          frame_load_o = 1'b1;
          rest_d       = res_i.quot;
          pos_d        = pos_q + 1'b1;
          first_d      = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign div_x_o = rest_q;

  assign frame_o.register_address = {1'b0, pos_q} + 4'd1;
  assign frame_o.digit_code       = blank ? BLANK_CODE : res_i.digit;
  assign frame_o.last_frame       = (pos_q == LAST_POS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q <= rest_d;
  end

`ifndef SYNTH
  a_load_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_load_o |-> (state_q == ST_EMIT) && out_free_i)
    else $error("frame loaded outside the emit step");

  a_last_ends_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_load_o && frame_o.last_frame |=> state_q == ST_IDLE)
    else $error("sequencer kept running after the last frame");
`endif

endmodule

// File: hdl/decimal_digit_frame_builder.sv
// Decimal digit frame builder for a code-B seven-segment display driver.
// A request on req_i carries start_digit and a 32-bit number_value. For each
// display position from start_digit up to DIGIT_COUNT-1 the block sends one
// frame on frame_o: register_address (position plus one), digit_code (the
// next decimal digit, least significant first, or 15 for a blank digit) and
// last_frame, set on the frame for the highest position.
// Leading zeros are blanked; a value of zero shows one 0 at the start position.
// Digits that do not fit on the display are dropped. A start position beyond
// the display produces no frame.
// req_i.ready is high only while the block is idle. One shared divide-by-ten
// unit produces a digit from a registered 32 by 32 multiply by the reciprocal
// of ten, then the correction and the frame load.
// When the receiver stalls, the frame waits in the output register and the
// sequencer holds its digit until the register is free again.
// Reset clears the sequencer and the output valid flag; no frame is pending.
module decimal_digit_frame_builder (
  input  logic         clk_i,
  input  logic         rst_ni,
  ddfb_req_if.sink     req_i,
  ddfb_frame_if.source frame_o
);
  import ddfb_pkg::*;

  logic               div_en;
  logic [VALUE_W-1:0] div_x;
  div_res_t           div_res;
  logic               out_free;
  logic               frame_load;
  frame_t             frame_next;
  logic               out_valid_q;
  frame_t             out_frame_q;

  ddfb_div10 u_div10 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (div_en),
    .x_i    (div_x),
    .res_o  (div_res)
  );

  ddfb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .res_i        (div_res),
    .out_free_i   (out_free),
    .div_en_o     (div_en),
    .div_x_o      (div_x),
    .frame_load_o (frame_load),
    .frame_o      (frame_next)
  );

  assign out_free = !out_valid_q || frame_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= frame_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_load) begin
      out_frame_q <= frame_next;
    end
  end

  assign frame_o.valid            = out_valid_q;
  assign frame_o.register_address = out_frame_q.register_address;
  assign frame_o.digit_code       = out_frame_q.digit_code;
  assign frame_o.last_frame       = out_frame_q.last_frame;

endmodule
